// File: rtl/core/differential_stepper_speed_drive_top_defines.svh
// ----------------------------------------------------------------------------
// Differential stepper speed drive assertion macros
// Shared property forms for the checkers of the drive.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_STEPPER_SPEED_DRIVE_TOP_DEFINES_SVH
`define DIFFERENTIAL_STEPPER_SPEED_DRIVE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSSD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dssd check failed");

// The consequent must hold in the cycle after the antecedent.
`define DSSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dssd check failed");

`endif

// File: rtl/core/dssd_pkg.sv
// ----------------------------------------------------------------------------
// Differential stepper speed drive package
// Widths, constants, step sequences and controller interface types.
// ----------------------------------------------------------------------------
package dssd_pkg;

   localparam int TICK_RATE   = 15625;
   localparam int DIVIDEND_W  = 16;
   localparam int DIVISOR_W   = 14;
   localparam int SPEED_W     = 16;
   localparam int DELTA_W     = 15;
   localparam int ERROR_W     = 8;
   localparam int BASE_W      = 10;
   localparam int GAIN_W      = 6;
   localparam int COUNT_W     = 8;
   localparam int PHASE_W     = 2;
   localparam int COILS_W     = 4;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [BASE_W-1:0] BASE_SPEED_RESET = BASE_W'(100);
   localparam logic [GAIN_W-1:0] GAIN_RESET       = GAIN_W'(10);

   localparam logic REG_BASE_SPEED = 1'b0;
   localparam logic REG_GAIN       = 1'b1;

   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;

   typedef struct packed {
      logic capture;
      logic tick;
      logic mult;
      logic div_start;
      logic div_right;
      logic set_left;
      logic set_right;
      logic stop_left;
      logic stop_right;
      logic load_rsp;
   } dssd_cmd_type;

   typedef struct packed {
      logic left_pos;
      logic right_pos;
      logic div_done;
   } dssd_stat_type;

   function automatic logic [COILS_W-1:0] left_seq(input logic [PHASE_W-1:0] phase);
      logic [COILS_W-1:0] pat;
      unique case (phase)
         2'd0: pat = 4'h9;
         2'd1: pat = 4'hC;
         2'd2: pat = 4'h6;
         default: pat = 4'h3;
      endcase
      return pat;
   endfunction

   function automatic logic [COILS_W-1:0] right_seq(input logic [PHASE_W-1:0] phase);
      logic [COILS_W-1:0] pat;
      unique case (phase)
         2'd0: pat = 4'h3;
         2'd1: pat = 4'h6;
         2'd2: pat = 4'hC;
         default: pat = 4'h9;
      endcase
      return pat;
   endfunction

endpackage

// File: rtl/core/dssd_div.sv
// ----------------------------------------------------------------------------
// Differential stepper speed drive divider
// Restoring divider of the tick rate by a speed, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dssd_div #(
   parameter int TICK_RATE = dssd_pkg::TICK_RATE
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [dssd_pkg::DIVISOR_W-1:0]  divisor,
   output logic                            done,
   output logic [dssd_pkg::DIVIDEND_W-1:0] quotient
);
   import dssd_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    rem_sh;
   logic [DIVISOR_W+1:0]  diff;

   assign rem_sh = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         dsr_in  = divisor;
         rem_in  = '0;
         quo_in  = DIVIDEND_W'(TICK_RATE);
      end else if (busy_ff) begin
         if (!diff[DIVISOR_W+1]) begin
            rem_in = diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/core/dssd_datapath.sv
// ----------------------------------------------------------------------------
// Differential stepper speed drive datapath
// Speed arithmetic, step timers, coil patterns and the response register.
// ----------------------------------------------------------------------------
module dssd_datapath #(
   parameter int TICK_RATE = dssd_pkg::TICK_RATE
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dssd_pkg::dssd_cmd_type               cmd,
   output dssd_pkg::dssd_stat_type              stat,
   input  logic signed [dssd_pkg::ERROR_W-1:0]  track_error,
   input  logic [dssd_pkg::BASE_W-1:0]          base_speed,
   input  logic [dssd_pkg::GAIN_W-1:0]          correction_gain,
   output logic [dssd_pkg::COILS_W-1:0]         left_coils,
   output logic [dssd_pkg::COILS_W-1:0]         right_coils,
   output logic                                 left_running,
   output logic                                 right_running
);
   import dssd_pkg::*;

   logic signed [ERROR_W-1:0] err_ff, err_in;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic signed [SPEED_W-1:0] base_ext, delta_ext, left_spd, right_spd;
   logic [DIVISOR_W-1:0]      divisor;
   logic                      div_done;
   logic [DIVIDEND_W-1:0]     quotient;
   logic [COUNT_W-1:0]        period;

   logic [COUNT_W-1:0] lcnt_ff, lcnt_in, rcnt_ff, rcnt_in;
   logic [COUNT_W-1:0] lcmp_ff, lcmp_in, rcmp_ff, rcmp_in;
   logic [PHASE_W-1:0] lph_ff, lph_in, rph_ff, rph_in;
   logic [COILS_W-1:0] lpat_ff, lpat_in, rpat_ff, rpat_in;
   logic               len_ff, len_in, ren_ff, ren_in;

   logic [COILS_W-1:0] out_lc_ff, out_rc_ff;
   logic               out_lr_ff, out_rr_ff;

   assign err_in   = cmd.capture ? track_error : err_ff;
   assign delta_in = cmd.mult
                   ? DELTA_W'(err_ff) * DELTA_W'($signed({1'b0, correction_gain}))
                   : delta_ff;

   assign base_ext  = $signed({{(SPEED_W-BASE_W){1'b0}}, base_speed});
   assign delta_ext = SPEED_W'(delta_ff);
   assign left_spd  = base_ext - delta_ext;
   assign right_spd = base_ext + delta_ext;

   assign stat.left_pos  = !left_spd[SPEED_W-1] && (left_spd != '0);
   assign stat.right_pos = !right_spd[SPEED_W-1] && (right_spd != '0);
   assign stat.div_done  = div_done;

   assign divisor = cmd.div_right ? right_spd[DIVISOR_W-1:0] : left_spd[DIVISOR_W-1:0];

   dssd_div #(
      .TICK_RATE (TICK_RATE)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      priority if (quotient == '0) begin
         period = '0;
      end else if (quotient > DIVIDEND_W'(256)) begin
         period = '1;
      end else begin
         period = COUNT_W'(quotient - DIVIDEND_W'(1));
      end
   end

   always_comb begin
      lcnt_in = lcnt_ff;
      rcnt_in = rcnt_ff;
      lcmp_in = lcmp_ff;
      rcmp_in = rcmp_ff;
      lph_in  = lph_ff;
      rph_in  = rph_ff;
      lpat_in = lpat_ff;
      rpat_in = rpat_ff;
      len_in  = len_ff;
      ren_in  = ren_ff;
      if (cmd.tick) begin
         if (lcnt_ff == lcmp_ff) begin
            lcnt_in = '0;
            if (len_ff) begin
               lpat_in = left_seq(lph_ff);
               lph_in  = lph_ff + PHASE_W'(1);
            end
         end else begin
            lcnt_in = lcnt_ff + COUNT_W'(1);
         end
         if (rcnt_ff == rcmp_ff) begin
            rcnt_in = '0;
            if (ren_ff) begin
               rpat_in = right_seq(rph_ff);
               rph_in  = rph_ff + PHASE_W'(1);
            end
         end else begin
            rcnt_in = rcnt_ff + COUNT_W'(1);
         end
      end
      if (cmd.set_left) begin
         lcmp_in = period;
         len_in  = 1'b1;
      end
      if (cmd.stop_left) begin
         len_in = 1'b0;
      end
      if (cmd.set_right) begin
         rcmp_in = period;
         ren_in  = 1'b1;
      end
      if (cmd.stop_right) begin
         ren_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lcnt_ff <= '0;
         rcnt_ff <= '0;
         lcmp_ff <= '0;
         rcmp_ff <= '0;
         lph_ff  <= '0;
         rph_ff  <= '0;
         lpat_ff <= '0;
         rpat_ff <= '0;
         len_ff  <= 1'b0;
         ren_ff  <= 1'b0;
      end else begin
         lcnt_ff <= lcnt_in;
         rcnt_ff <= rcnt_in;
         lcmp_ff <= lcmp_in;
         rcmp_ff <= rcmp_in;
         lph_ff  <= lph_in;
         rph_ff  <= rph_in;
         lpat_ff <= lpat_in;
         rpat_ff <= rpat_in;
         len_ff  <= len_in;
         ren_ff  <= ren_in;
      end
      err_ff   <= err_in;
      delta_ff <= delta_in;
      if (cmd.load_rsp) begin
         out_lc_ff <= lpat_ff;
         out_rc_ff <= rpat_ff;
         out_lr_ff <= len_ff;
         out_rr_ff <= ren_ff;
      end
   end

   assign left_coils    = out_lc_ff;
   assign right_coils   = out_rc_ff;
   assign left_running  = out_lr_ff;
   assign right_running = out_rr_ff;

endmodule

// File: rtl/core/dssd_ctrl.sv
// ----------------------------------------------------------------------------
// Differential stepper speed drive controller
// Sequences ticks and speed updates and owns both handshakes.
// ----------------------------------------------------------------------------
module dssd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_command,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output dssd_pkg::dssd_cmd_type  cmd,
   input  dssd_pkg::dssd_stat_type stat
);
   import dssd_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MULT  = 3'd1;
   localparam logic [2:0] ST_LEFT  = 3'd2;
   localparam logic [2:0] ST_LDIV  = 3'd3;
   localparam logic [2:0] ST_RIGHT = 3'd4;
   localparam logic [2:0] ST_RDIV  = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_command == CMD_UPDATE) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_MULT;
               end else begin
                  cmd.tick = 1'b1;
                  state_in = ST_DONE;
               end
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_LEFT;
         end
         ST_LEFT: begin
            if (stat.left_pos) begin
               cmd.div_start = 1'b1;
               state_in      = ST_LDIV;
            end else begin
               cmd.stop_left = 1'b1;
               state_in      = ST_RIGHT;
            end
         end
         ST_LDIV: begin
            if (stat.div_done) begin
               cmd.set_left = 1'b1;
               state_in     = ST_RIGHT;
            end
         end
         ST_RIGHT: begin
            cmd.div_right = 1'b1;
            if (stat.right_pos) begin
               cmd.div_start = 1'b1;
               state_in      = ST_RDIV;
            end else begin
               cmd.stop_right = 1'b1;
               state_in       = ST_DONE;
            end
         end
         ST_RDIV: begin
            if (stat.div_done) begin
               cmd.set_right = 1'b1;
               state_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/core/differential_stepper_speed_drive_top.sv
// ----------------------------------------------------------------------------
// Differential stepper speed drive
// Drives two 4-phase stepper motors at speeds set by a line-tracking error.
// A tick request advances both step timers. An update request computes
// base_speed minus and plus error times gain, turns each positive speed into
// a compare period with one run of the shared 16-step restoring divider and
// stops each motor whose speed is not positive. The divider sets the update
// time. A new request is taken while the previous response still waits in
// the output register. Both registers sit behind the APB-style port; the
// user must write them only while no request is in flight, as the block
// does not enforce it.
// ----------------------------------------------------------------------------
module differential_stepper_speed_drive_top #(
   parameter int TICK_RATE = dssd_pkg::TICK_RATE
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_command,
   input  logic signed [dssd_pkg::ERROR_W-1:0]  req_track_error,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [dssd_pkg::COILS_W-1:0]         rsp_left_coils,
   output logic [dssd_pkg::COILS_W-1:0]         rsp_right_coils,
   output logic                                 rsp_left_running,
   output logic                                 rsp_right_running,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [dssd_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [dssd_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [dssd_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import dssd_pkg::*;

   logic [BASE_W-1:0] base_ff, base_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic              csr_wr;
   dssd_cmd_type      cmd;
   dssd_stat_type     stat;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      base_in = base_ff;
      gain_in = gain_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_BASE_SPEED: base_in = csr_pwdata[BASE_W-1:0];
            REG_GAIN:       gain_in = csr_pwdata[GAIN_W-1:0];
            default:        base_in = base_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_BASE_SPEED: csr_prdata = CSR_DATA_W'(base_ff);
         REG_GAIN:       csr_prdata = CSR_DATA_W'(gain_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_SPEED_RESET;
         gain_ff <= GAIN_RESET;
      end else begin
         base_ff <= base_in;
         gain_ff <= gain_in;
      end
   end

   dssd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .cmd         (cmd),
      .stat        (stat)
   );

   dssd_datapath #(
      .TICK_RATE (TICK_RATE)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .track_error     (req_track_error),
      .base_speed      (base_ff),
      .correction_gain (gain_ff),
      .left_coils      (rsp_left_coils),
      .right_coils     (rsp_right_coils),
      .left_running    (rsp_left_running),
      .right_running   (rsp_right_running)
   );

endmodule

// File: rtl/core/dssd_checker.sv
// ----------------------------------------------------------------------------
// Differential stepper speed drive checker
// Port-level checks of the drive, bound to the top level.
// ----------------------------------------------------------------------------
`include "differential_stepper_speed_drive_top_defines.svh"

module dssd_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [dssd_pkg::COILS_W-1:0]         rsp_left_coils,
   input logic [dssd_pkg::COILS_W-1:0]         rsp_right_coils,
   input logic                                 rsp_left_running,
   input logic                                 rsp_right_running
);
   import dssd_pkg::*;

   logic [2*COILS_W+1:0] rsp_word;

   assign rsp_word = {rsp_left_coils, rsp_right_coils, rsp_left_running, rsp_right_running};

   // After reset the block is ready for a request and has no response pending.
   `DSSD_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, req_ready && !rsp_valid)

   // Every accepted request leaves the block busy, not ready, in the cycle after acceptance.
   `DSSD_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, !req_ready)

   // A stalled response keeps its valid and its payload.
   `DSSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

endmodule

bind differential_stepper_speed_drive_top dssd_checker u_checker (.*);

// File: tb/tb_differential_stepper_speed_drive_top.sv
// ----------------------------------------------------------------------------
// Differential stepper speed drive testbench
// Sends tick and error update requests through the valid/ready request port,
// predicts the coil patterns and run flags of both motors for every accepted
// request, and checks each response in order. A directed table covers reset,
// the speed and error extremes, stopping and restarting the motors and long
// and zero periods. Random phases follow under several register settings,
// with random idling on both sides and a long response hold-off.
// ----------------------------------------------------------------------------
module tb_differential_stepper_speed_drive_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dssd_pkg::*;

   localparam int CYCLE_LIMIT    = 600000;
   localparam int PHASES         = 9;
   localparam int PHASE_REQUESTS = 210;
   localparam int SETTLE_CYCLES  = 4;
   localparam int TAIL_CYCLES    = 50;
   localparam int HOLD_CYCLES    = 400;
   localparam int IDLE_PERCENT   = 18;
   localparam int DIRECTED_ROWS  = 27;
   localparam logic [15:0] LEFT_STEPS  = 16'h36C9;
   localparam logic [15:0] RIGHT_STEPS = 16'h9C63;

   typedef enum logic {ROW_REQUEST, ROW_CSR_WRITE} row_kind_type;

   typedef struct packed {
      logic [COILS_W-1:0] left_coils;
      logic [COILS_W-1:0] right_coils;
      logic               left_running;
      logic               right_running;
   } drive_out_type;

   typedef struct {
      row_kind_type  kind;
      logic          sel;
      int            value;
      bit            fixed;
      drive_out_type want;
   } stim_row_type;

   typedef struct {
      bit            fixed;
      drive_out_type want;
   } fixed_want_type;

   typedef struct {
      logic [COUNT_W-1:0] count;
      logic [COUNT_W-1:0] compare;
      logic [PHASE_W-1:0] phase;
      logic [COILS_W-1:0] pattern;
      logic               enable;
   } motor_state_type;

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic                         req_command = CMD_TICK;
   logic signed [ERROR_W-1:0]    req_track_error = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [COILS_W-1:0]           rsp_left_coils;
   logic [COILS_W-1:0]           rsp_right_coils;
   logic                         rsp_left_running;
   logic                         rsp_right_running;
   logic                         csr_psel = 1'b0;
   logic                         csr_penable = 1'b0;
   logic                         csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]        csr_paddr = '0;
   logic [CSR_DATA_W-1:0]        csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]        csr_prdata;
   logic                         csr_pready;

   logic [BASE_W-1:0]   base_speed_reg;
   logic [GAIN_W-1:0]   gain_reg;
   motor_state_type     left_motor;
   motor_state_type     right_motor;
   drive_out_type       drive_q[$];
   fixed_want_type      fixed_q[$];
   int                  mismatch_count = 0;
   int                  cycle_count = 0;
   int                  hold_asked = 0;
   int                  hold_seen = 0;
   int                  hold_left = 0;
   bit                  quiet = 1'b0;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_REQUEST,   CMD_TICK,       0,    1'b1, '{4'h0, 4'h0, 1'b0, 1'b0}},
      '{ROW_REQUEST,   CMD_UPDATE,     0,    1'b1, '{4'h0, 4'h0, 1'b1, 1'b1}},
      '{ROW_REQUEST,   CMD_UPDATE,     -128, 1'b1, '{4'h0, 4'h0, 1'b1, 1'b0}},
      '{ROW_REQUEST,   CMD_UPDATE,     127,  1'b1, '{4'h0, 4'h0, 1'b0, 1'b1}},
      '{ROW_CSR_WRITE, REG_BASE_SPEED, 1023, 1'b0, '0},
      '{ROW_CSR_WRITE, REG_GAIN,       63,   1'b0, '0},
      '{ROW_REQUEST,   CMD_UPDATE,     127,  1'b1, '{4'h0, 4'h0, 1'b0, 1'b1}},
      '{ROW_REQUEST,   CMD_TICK,       0,    1'b1, '{4'h0, 4'h3, 1'b0, 1'b1}},
      '{ROW_REQUEST,   CMD_TICK,       0,    1'b0, '0},
      '{ROW_REQUEST,   CMD_TICK,       0,    1'b0, '0},
      '{ROW_REQUEST,   CMD_TICK,       0,    1'b0, '0},
      '{ROW_REQUEST,   CMD_UPDATE,     -128, 1'b0, '0},
      '{ROW_REQUEST,   CMD_TICK,       0,    1'b0, '0},
      '{ROW_REQUEST,   CMD_TICK,       0,    1'b0, '0},
      '{ROW_REQUEST,   CMD_UPDATE,     1,    1'b0, '0},
      '{ROW_REQUEST,   CMD_TICK,       0,    1'b0, '0},
      '{ROW_CSR_WRITE, REG_BASE_SPEED, 0,    1'b0, '0},
      '{ROW_REQUEST,   CMD_UPDATE,     0,    1'b0, '0},
      '{ROW_REQUEST,   CMD_TICK,       0,    1'b0, '0},
      '{ROW_CSR_WRITE, REG_GAIN,       0,    1'b0, '0},
      '{ROW_REQUEST,   CMD_UPDATE,     -1,   1'b0, '0},
      '{ROW_CSR_WRITE, REG_BASE_SPEED, 1,    1'b0, '0},
      '{ROW_REQUEST,   CMD_UPDATE,     5,    1'b0, '0},
      '{ROW_REQUEST,   CMD_TICK,       0,    1'b0, '0},
      '{ROW_CSR_WRITE, REG_GAIN,       1,    1'b0, '0},
      '{ROW_REQUEST,   CMD_UPDATE,     1,    1'b0, '0},
      '{ROW_REQUEST,   CMD_TICK,       0,    1'b0, '0}
   };

   differential_stepper_speed_drive_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_track_error   (req_track_error),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_left_coils    (rsp_left_coils),
      .rsp_right_coils   (rsp_right_coils),
      .rsp_left_running  (rsp_left_running),
      .rsp_right_running (rsp_right_running),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic motor_state_type set_motor_speed(motor_state_type m, int speed);
      int period;
      if (speed <= 0) begin
         m.enable = 1'b0;
      end else begin
         period = TICK_RATE / speed - 1;
         if (period < 0) period = 0;
         if (period > 255) period = 255;
         m.compare = COUNT_W'(period);
         m.enable = 1'b1;
      end
      return m;
   endfunction

   function automatic motor_state_type tick_motor(motor_state_type m, logic [15:0] steps);
      if (m.count == m.compare) begin
         m.count = '0;
         if (m.enable) begin
            m.pattern = steps[4*m.phase +: 4];
            m.phase = m.phase + 1'b1;
         end
      end else begin
         m.count = m.count + 1'b1;
      end
      return m;
   endfunction

   function automatic drive_out_type predict_drive(logic command,
                                                   logic signed [ERROR_W-1:0] err);
      int e;
      int g;
      int base;
      drive_out_type r;
      e = err;
      g = gain_reg;
      base = base_speed_reg;
      if (command == CMD_UPDATE) begin
         left_motor = set_motor_speed(left_motor, base - e * g);
         right_motor = set_motor_speed(right_motor, base + e * g);
      end else begin
         left_motor = tick_motor(left_motor, LEFT_STEPS);
         right_motor = tick_motor(right_motor, RIGHT_STEPS);
      end
      r.left_coils = left_motor.pattern;
      r.right_coils = right_motor.pattern;
      r.left_running = left_motor.enable;
      r.right_running = right_motor.enable;
      return r;
   endfunction

   function automatic void flag_field(string field, int want, int got);
      if (want != got) begin
         if (mismatch_count < 10)
            $display("mismatch on %s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : watch_drive
      drive_out_type  want;
      drive_out_type  got;
      fixed_want_type pin;
      if (!reset) begin
         if (req_valid && req_ready) begin
            want = predict_drive(req_command, req_track_error);
            pin = fixed_q.pop_front();
            drive_q.push_back(pin.fixed ? pin.want : want);
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_left_coils, rsp_right_coils, rsp_left_running, rsp_right_running};
            if (drive_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("response with no request outstanding");
               mismatch_count++;
            end else begin
               want = drive_q.pop_front();
               flag_field("left_coils", want.left_coils, got.left_coils);
               flag_field("right_coils", want.right_coils, got.right_coils);
               flag_field("left_running", want.left_running, got.left_running);
               flag_field("right_running", want.right_running, got.right_running);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_asked) begin
         hold_seen = hold_asked;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (quiet) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_differential_stepper_speed_drive_top: FAIL");
         $finish;
      end
   end

   task automatic send_request(logic command, logic signed [ERROR_W-1:0] err, bit fixed,
                               drive_out_type want);
      fixed_want_type pin;
      if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      pin.fixed = fixed;
      pin.want = want;
      fixed_q.push_back(pin);
      req_valid <= 1'b1;
      req_command <= command;
      req_track_error <= err;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (drive_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic index, logic [CSR_DATA_W-1:0] data);
      int stored;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (index == REG_BASE_SPEED) begin
         base_speed_reg = data[BASE_W-1:0];
         stored = base_speed_reg;
      end else begin
         gain_reg = data[GAIN_W-1:0];
         stored = gain_reg;
      end
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      flag_field("register readback", stored, csr_prdata);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [ERROR_W-1:0] pick_error();
      int mag;
      case ($urandom_range(9))
         0, 1, 2, 3: pick_error = ERROR_W'($urandom_range(255));
         4, 5, 6: begin
            mag = $urandom_range(96, 128);
            pick_error = $urandom_range(1) ? ERROR_W'(-mag) : ERROR_W'(mag);
         end
         default: pick_error = ERROR_W'(int'($urandom_range(12)) - 6);
      endcase
   endfunction

   initial begin
      int base;
      int gain;
      logic [CSR_DATA_W-1:0] junk;
      base_speed_reg = BASE_SPEED_RESET;
      gain_reg = GAIN_RESET;
      left_motor = '{'0, '0, '0, '0, 1'b0};
      right_motor = '{'0, '0, '0, '0, 1'b0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR_WRITE) begin
            wait_for_drain();
            write_csr(directed_rows[i].sel, CSR_DATA_W'(directed_rows[i].value));
         end else begin
            send_request(directed_rows[i].sel, ERROR_W'(directed_rows[i].value),
                         directed_rows[i].fixed, directed_rows[i].want);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin base = 1023; gain = 63; end
            1: begin base = 0; gain = 0; end
            2: begin base = 1023; gain = 0; end
            3: begin base = 0; gain = 63; end
            4: begin base = BASE_SPEED_RESET; gain = GAIN_RESET; end
            default: begin base = $urandom_range(1023); gain = $urandom_range(63); end
         endcase
         quiet = (p == 6);
         wait_for_drain();
         junk = (p >= 5) ? CSR_DATA_W'($urandom) : '0;
         write_csr(REG_BASE_SPEED, {junk[CSR_DATA_W-1:BASE_W], BASE_W'(base)});
         write_csr(REG_GAIN, {junk[CSR_DATA_W-1:GAIN_W], GAIN_W'(gain)});
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (p == 0 && n == 20) hold_asked++;
            if ($urandom_range(99) < 15)
               send_request(CMD_UPDATE, pick_error(), 1'b0, '0);
            else
               send_request(CMD_TICK, ERROR_W'($urandom_range(255)), 1'b0, '0);
         end
      end
      quiet = 1'b0;

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (drive_q.size() != 0) mismatch_count++;
      if (mismatch_count == 0)
         $display("tb_differential_stepper_speed_drive_top: PASS");
      else
         $display("tb_differential_stepper_speed_drive_top: FAIL");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/dssd_pkg.sv
rtl/core/dssd_div.sv
rtl/core/dssd_datapath.sv
rtl/core/dssd_ctrl.sv
rtl/core/differential_stepper_speed_drive_top.sv
rtl/core/dssd_checker.sv
tb/tb_differential_stepper_speed_drive_top.sv
